// File: rtl/bvmm_pkg.sv
`timescale 1ns / 1ps
// bvmm_pkg: widths, constants, register indexes and shared types of the
// battery voltage median monitor; no dependencies
package bvmm_pkg;

    localparam int RAW_W         = 12;
    localparam int MV_W          = 16;
    localparam int BURST_SAMPLES = 16;
    localparam int CNT_W         = $clog2(BURST_SAMPLES + 1);
    localparam int IDX_W         = (BURST_SAMPLES > 1) ? $clog2(BURST_SAMPLES) : 1;
    localparam int CLIP_LIMIT    = BURST_SAMPLES / 4;

    localparam int AVG_DEPTH = 8;
    localparam int POS_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int DEPTH_W   = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W     = RAW_W + $clog2(AVG_DEPTH + 1);

    localparam int PROD_W = 2 * RAW_W;
    localparam int Q_FRAC = 8;

    localparam logic [RAW_W-1:0] MV_FULL_SCALE = RAW_W'(3300);
    localparam logic [RAW_W-1:0] ADC_MAX       = RAW_W'(4095);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVIDER_RATIO = 3'd0,
        CFG_RAIL_LEVEL    = 3'd1,
        CFG_ARM_MIN       = 3'd2,
        CFG_OPERATE_MIN   = 3'd3,
        CFG_CRITICAL      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LOW      = 2'd1,
        STATUS_WARNING  = 2'd2,
        STATUS_CRITICAL = 2'd3
    } status_t;

    // link between neighboring sort cells
    typedef struct packed {
        logic             gt;
        logic [RAW_W-1:0] val;
    } link_t;

endpackage

// File: rtl/bvmm_cell.sv
`timescale 1ns / 1ps
// bvmm_cell: one slot of the sorted insertion chain
// depends on bvmm_pkg
module bvmm_cell (
    input  logic                      aclk,
    input  logic                      ins_en,
    input  logic [bvmm_pkg::RAW_W-1:0] ins_val,
    input  logic                      occupied,
    input  bvmm_pkg::link_t           left,
    output bvmm_pkg::link_t           right
);
    import bvmm_pkg::*;

    logic [RAW_W-1:0] val_reg;
    logic             gt;

    // an empty slot acts as larger than anything
    assign gt    = !occupied || (val_reg > ins_val);
    assign right = '{gt: gt, val: val_reg};

    always_ff @(posedge aclk) begin
        if (ins_en && gt) begin
            val_reg <= left.gt ? left.val : ins_val;
        end
    end

endmodule

// File: rtl/bvmm_div.sv
`timescale 1ns / 1ps
// bvmm_div: restoring divider, one quotient bit per cycle
// depends on bvmm_pkg
module bvmm_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bvmm_pkg::SUM_W-1:0]   dividend,
    input  logic [bvmm_pkg::DEPTH_W-1:0] divisor,
    output logic                         done,
    output logic [bvmm_pkg::SUM_W-1:0]   quotient
);
    import bvmm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic [SUM_W-1:0]   quo_reg;
    logic [DEPTH_W-1:0] rem_reg;
    logic [DEPTH_W-1:0] dsr_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DEPTH_W:0]   rem_sh;
    logic               fits;
    logic [DEPTH_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DEPTH_W-1:0] : rem_sh[DEPTH_W-1:0];
        end
    end

endmodule

// File: rtl/battery_voltage_median_monitor.sv
`timescale 1ns / 1ps
// battery_voltage_median_monitor: top level, burst control, ring average,
// scaling and classification; depends on bvmm_pkg, bvmm_cell, bvmm_div
//
// Usage:
//   Input words (s_tvalid/s_tready) are converter read attempts: s_tdata
//   holds raw_count, s_tuser[0] holds read_ok. Good samples are inserted
//   into a chain of sort cells, one word per cycle. Every 16th attempt
//   closes a burst and produces one output word (m_tvalid/m_tready).
//   Output m_tdata holds batt_mv, status and clipped_count; m_tuser
//   holds clip_fault and read_failed.
//   Throughput: words of a burst are taken one per cycle; after the last
//   word of a burst the input is held off while the median is converted,
//   pushed into the 8-entry ring and averaged. The average goes through a
//   bit-serial divider, so a burst with good samples holds off the input
//   longer than a burst with none, which skips the ring and the divider.
//   The output word sits in a register: the next burst is collected while
//   it waits; the block only stalls when a new result is ready before the
//   previous one has been taken.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at
//   once and are to be made while the block is idle.
//   Reset (synchronous, aresetn low) clears counters, the ring, the last
//   voltage and restores register defaults; no clearing pass is needed.
module battery_voltage_median_monitor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bvmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bvmm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // raw_count[11:0], zero [15:12]
    input  logic [0:0]                          s_tuser,  // read_ok[0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,  // batt_mv[15:0], status[17:16],
                                                          // clipped_count[22:18], zero [23]
    output logic [1:0]                          m_tuser   // clip_fault[0], read_failed[1]
);
    import bvmm_pkg::*;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_MED,
        S_CONV,
        S_DIV,
        S_SCALE,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [RAW_W-1:0] ratio_reg;
    logic [RAW_W-1:0] rail_reg;
    logic [MV_W-1:0]  arm_reg;
    logic [MV_W-1:0]  operate_reg;
    logic [MV_W-1:0]  critical_reg;

    logic [CNT_W-1:0] good_reg;
    logic [CNT_W-1:0] attempt_reg;
    logic [CNT_W-1:0] clip_reg;
    logic             failed_reg;

    logic [RAW_W-1:0] ring_reg [AVG_DEPTH];
    logic [POS_W-1:0] pos_reg;
    logic             full_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [MV_W-1:0]  last_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [RAW_W-1:0]  avg_reg;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    // input side
    logic             in_acc;
    logic [RAW_W-1:0] raw;
    logic             ok;
    logic             ins_en;

    assign s_tready = (state_reg == S_COLLECT);
    assign in_acc   = s_tvalid && s_tready;
    assign raw      = s_tdata[RAW_W-1:0];
    assign ok       = s_tuser[0];
    assign ins_en   = in_acc && ok && (good_reg < CNT_W'(BURST_SAMPLES));

    // sort chain
    link_t            links [BURST_SAMPLES+1];
    logic [RAW_W-1:0] cell_val [BURST_SAMPLES];

    assign links[0] = '{gt: 1'b0, val: '0};

    for (genvar i = 0; i < BURST_SAMPLES; i++) begin : g_cell
        logic occ;
        assign occ         = CNT_W'(i) < good_reg;
        assign cell_val[i] = links[i+1].val;
        bvmm_cell u_cell (
            .aclk     (aclk),
            .ins_en   (ins_en),
            .ins_val  (raw),
            .occupied (occ),
            .left     (links[i]),
            .right    (links[i+1])
        );
    end

    logic [CNT_W-1:0] med_pos;
    logic [RAW_W-1:0] median;

    assign med_pos = good_reg >> 1;
    assign median  = cell_val[med_pos[IDX_W-1:0]];

    // divide by 4095: x = a*4096 + b = a*4095 + (a + b), and a + b < 2*4095
    logic [RAW_W-1:0] conv_hi;
    logic [RAW_W-1:0] conv_lo;
    logic [RAW_W:0]   conv_rest;
    logic [RAW_W-1:0] mv;

    assign conv_hi   = prod_reg[PROD_W-1:RAW_W];
    assign conv_lo   = prod_reg[RAW_W-1:0];
    assign conv_rest = {1'b0, conv_hi} + {1'b0, conv_lo};
    assign mv        = conv_hi + RAW_W'(conv_rest >= {1'b0, ADC_MAX});

    // ring update
    logic [POS_W-1:0]   pos_next;
    logic               full_next;
    logic [SUM_W-1:0]   sum_next;
    logic [DEPTH_W-1:0] count_next;
    logic               pos_wrap;

    assign pos_wrap   = (pos_reg == POS_W'(AVG_DEPTH - 1));
    assign pos_next   = pos_wrap ? '0 : pos_reg + 1'b1;
    assign full_next  = full_reg || pos_wrap;
    assign sum_next   = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(mv);
    assign count_next = full_next ? DEPTH_W'(AVG_DEPTH) : DEPTH_W'(pos_next);

    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    assign div_start = (state_reg == S_CONV);

    bvmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    // classification, critical first
    status_t status;

    always_comb begin
        if (last_reg < critical_reg) begin
            status = STATUS_CRITICAL;
        end else if (last_reg < operate_reg) begin
            status = STATUS_WARNING;
        end else if (last_reg < arm_reg) begin
            status = STATUS_LOW;
        end else begin
            status = STATUS_OK;
        end
    end

    logic out_free;
    logic out_load;
    logic clip_fault;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == S_OUT) && out_free;
    assign clip_fault = clip_reg > CNT_W'(CLIP_LIMIT);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg    <= RAW_W'(256);
            rail_reg     <= ADC_MAX;
            arm_reg      <= '0;
            operate_reg  <= '0;
            critical_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DIVIDER_RATIO: ratio_reg    <= cfg_data[RAW_W-1:0];
                CFG_RAIL_LEVEL:    rail_reg     <= cfg_data[RAW_W-1:0];
                CFG_ARM_MIN:       arm_reg      <= cfg_data[MV_W-1:0];
                CFG_OPERATE_MIN:   operate_reg  <= cfg_data[MV_W-1:0];
                CFG_CRITICAL:      critical_reg <= cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // burst control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_COLLECT;
            good_reg     <= '0;
            attempt_reg  <= '0;
            clip_reg     <= '0;
            failed_reg   <= 1'b0;
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            sum_reg      <= '0;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < AVG_DEPTH; k++) begin
                ring_reg[k] <= '0;
            end
        end else begin
            // a new word may replace the one taken at this edge
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_COLLECT: begin
                    if (in_acc) begin
                        if (ins_en) begin
                            good_reg <= good_reg + 1'b1;
                        end
                        if (ok && (raw >= rail_reg)) begin
                            clip_reg <= clip_reg + 1'b1;
                        end
                        attempt_reg <= attempt_reg + 1'b1;
                        if (attempt_reg == CNT_W'(BURST_SAMPLES - 1)) begin
                            state_reg <= S_MED;
                        end
                    end
                end
                S_MED: begin
                    prod_reg   <= PROD_W'(median) * PROD_W'(MV_FULL_SCALE);
                    failed_reg <= (good_reg == '0);
                    state_reg  <= (good_reg == '0) ? S_OUT : S_CONV;
                end
                S_CONV: begin
                    ring_reg[pos_reg] <= mv;
                    pos_reg           <= pos_next;
                    full_reg          <= full_next;
                    sum_reg           <= sum_next;
                    state_reg         <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        avg_reg   <= div_quo[RAW_W-1:0];
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    prod_reg  <= PROD_W'(avg_reg) * PROD_W'(ratio_reg);
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    // 12 x 12 bit product shifted by 8 always fits 16 bits
                    last_reg  <= prod_reg[Q_FRAC +: MV_W];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {1'b0, clip_reg, status, last_reg};
                        m_tuser_reg  <= {failed_reg, clip_fault};
                        good_reg     <= '0;
                        attempt_reg  <= '0;
                        clip_reg     <= '0;
                        state_reg    <= S_COLLECT;
                    end
                end
                default: begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
